>>> sv/vrx_pkg.sv
// ----------------------------------------------------------------------------
// vrx_pkg
// Shared types and constants of the video-transmitter response receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package vrx_pkg;

	// Frame layout
	localparam int unsigned FrameLen = 16;
	localparam int unsigned PosW     = $clog2(FrameLen);
	localparam int unsigned CksumPos = 14;

	localparam logic [7:0] LEN_BYTE      = 8'h0F;
	localparam logic [7:0] CODE_LIMITS   = 8'h72; // 'r'
	localparam logic [7:0] CODE_SETTINGS = 8'h76; // 'v'
	localparam logic [7:0] CODE_TEMP     = 8'h73; // 's'

	// Request action codes
	localparam logic ACT_BYTE   = 1'b0;
	localparam logic ACT_RESYNC = 1'b1;

	typedef enum logic [1:0] {
		PH_WAIT_LEN  = 2'd0,
		PH_WAIT_CODE = 2'd1,
		PH_DATA      = 2'd2
	} rx_phase_t;

	typedef enum logic [1:0] {
		KIND_LIMITS   = 2'd0,
		KIND_SETTINGS = 2'd1,
		KIND_TEMP     = 2'd2
	} kind_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         response_kind;
		logic [15:0]        min_frequency;
		logic [15:0]        max_frequency;
		logic [15:0]        max_power;
		logic [15:0]        current_frequency;
		logic [15:0]        configured_power;
		logic [7:0]         pit_mode;
		logic [15:0]        actual_power;
		logic signed [15:0] temperature;
	} out_item_t;

	// Completed frame from the framer to the decoder
	typedef struct packed {
		logic       done;   // good frame finished this cycle
		logic [7:0] code;   // byte 1
		logic [15:0] w2;    // bytes 2,3
		logic [15:0] w4;    // bytes 4,5
		logic [15:0] w6;    // bytes 6,7
		logic [15:0] w8;    // bytes 8,9
	} frame_evt_t;

endpackage

`default_nettype wire

>>> sv/vrx_in_if.sv
// ----------------------------------------------------------------------------
// vrx_in_if
// Request channel carrying received bytes and resync actions.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrx_in_if;
	logic              valid;
	logic              ready;
	vrx_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> sv/vrx_out_if.sv
// ----------------------------------------------------------------------------
// vrx_out_if
// Result channel carrying decoded response values.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrx_out_if;
	logic               valid;
	logic               ready;
	vrx_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> sv/vrx_framer.sv
// ----------------------------------------------------------------------------
// vrx_framer
// Frame sync, byte capture and running checksum for 16-byte response frames.
// ----------------------------------------------------------------------------
`default_nettype none

module vrx_framer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,      // request accepted this cycle
	input  wire vrx_pkg::in_item_t req,
	output vrx_pkg::frame_evt_t    evt,
	output logic                   last_byte  // next byte may finish a frame
);
	import vrx_pkg::*;

	rx_phase_t        phase_q, phase_n;
	logic [PosW-1:0]  pos_q, pos_n;
	logic [7:0]       sum_q, sum_n;
	logic [7:0]       frame_q [FrameLen];
	logic             is_byte;
	logic             code_ok;
	logic             at_last;

	assign is_byte = fire && (req.action == ACT_BYTE);
	assign code_ok = (req.rx_byte == CODE_LIMITS) || (req.rx_byte == CODE_SETTINGS) ||
	                 (req.rx_byte == CODE_TEMP);
	assign at_last = (pos_q == PosW'(FrameLen - 1));

	// Next phase, position and checksum
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		sum_n   = sum_q;
		if (fire && req.action == ACT_RESYNC) begin
			phase_n = PH_WAIT_LEN;
			pos_n   = '0;
			sum_n   = '0;
		end else if (is_byte) begin
			pos_n = pos_q + 1'b1;
			if (pos_q >= PosW'(1) && pos_q < PosW'(CksumPos))
				sum_n = sum_q + req.rx_byte;
			case (phase_q)
				PH_WAIT_LEN: begin
					if (req.rx_byte == LEN_BYTE) begin
						phase_n = PH_WAIT_CODE;
					end else begin
						pos_n = '0;
						sum_n = '0;
					end
				end
				PH_WAIT_CODE: begin
					if (code_ok) begin
						phase_n = PH_DATA;
					end else begin
						phase_n = PH_WAIT_LEN;
						pos_n   = '0;
						sum_n   = '0;
					end
				end
				PH_DATA: begin
					if (at_last) begin
						phase_n = PH_WAIT_LEN;
						pos_n   = '0;
						sum_n   = '0;
					end
				end
				default: begin
					phase_n = PH_WAIT_LEN;
					pos_n   = '0;
					sum_n   = '0;
				end
			endcase
		end
	end

	// Frame completion and decoder view of the stored bytes
	always_comb begin
		last_byte = (phase_q == PH_DATA) && at_last;
		evt.done  = is_byte && last_byte && (frame_q[CksumPos] == sum_q) &&
		            (req.rx_byte == 8'h00);
		evt.code  = frame_q[1];
		evt.w2    = {frame_q[3], frame_q[2]};
		evt.w4    = {frame_q[5], frame_q[4]};
		evt.w6    = {frame_q[7], frame_q[6]};
		evt.w8    = {frame_q[9], frame_q[8]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_LEN;
			pos_q   <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			sum_q   <= sum_n;
		end
	end

	// Capture each byte at its frame position
	always_ff @(posedge clk) begin
		if (is_byte)
			frame_q[pos_q] <= req.rx_byte;
	end

endmodule

`default_nettype wire

>>> sv/vrx_decoder.sv
// ----------------------------------------------------------------------------
// vrx_decoder
// Field decode of good frames into held values, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vrx_decoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vrx_pkg::frame_evt_t evt,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output vrx_pkg::out_item_t       out_item,
	output logic                     room       // result register can load
);
	import vrx_pkg::*;

	kind_t       kind_q, kind_n;
	logic        valid_q;
	logic        load;
	logic [15:0] key;
	logic        known;
	logic [15:0] min_freq_q, max_freq_q, max_power_q;
	logic [15:0] cur_freq_q, conf_power_q, act_power_q;
	logic [7:0]  pit_mode_q;
	logic [15:0] temp_q;

	// Select kind and key field from the response code
	always_comb begin
		known  = 1'b1;
		kind_n = KIND_LIMITS;
		key    = evt.w2;
		case (evt.code)
			CODE_LIMITS:   kind_n = KIND_LIMITS;
			CODE_SETTINGS: kind_n = KIND_SETTINGS;
			CODE_TEMP: begin
				kind_n = KIND_TEMP;
				key    = evt.w6;
			end
			default:       known = 1'b0;
		endcase
	end

	assign room = !valid_q || out_ready;
	assign load = evt.done && known && (key != 16'h0000);

	// Result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kind_q  <= KIND_LIMITS;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				kind_q  <= kind_n;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Update the held values of the decoded response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_q   <= '0;
			max_freq_q   <= '0;
			max_power_q  <= '0;
			cur_freq_q   <= '0;
			conf_power_q <= '0;
			pit_mode_q   <= '0;
			act_power_q  <= '0;
			temp_q       <= '0;
		end else if (load) begin
			case (kind_n)
				KIND_LIMITS: begin
					min_freq_q  <= evt.w2;
					max_freq_q  <= evt.w4;
					max_power_q <= evt.w6;
				end
				KIND_SETTINGS: begin
					cur_freq_q   <= evt.w2;
					conf_power_q <= evt.w4;
					pit_mode_q   <= evt.w6[15:8];
					act_power_q  <= evt.w8;
				end
				KIND_TEMP:     temp_q <= evt.w6;
				default:       ;
			endcase
		end
	end

	// Held values stay put while a result waits, so they drive the payload
	always_comb begin
		out_valid                  = valid_q;
		out_item.response_kind     = kind_q;
		out_item.min_frequency     = min_freq_q;
		out_item.max_frequency     = max_freq_q;
		out_item.max_power         = max_power_q;
		out_item.current_frequency = cur_freq_q;
		out_item.configured_power  = conf_power_q;
		out_item.pit_mode          = pit_mode_q;
		out_item.actual_power      = act_power_q;
		out_item.temperature       = temp_q;
	end

endmodule

`default_nettype wire

>>> sv/vtx_response_frame_receiver.sv
// ----------------------------------------------------------------------------
// vtx_response_frame_receiver
// Receives 16-byte video-transmitter response frames and decodes them.
//
// Request channel in_ch: one byte per request (action 0) or a resync
// (action 1) that drops any partial frame and waits for the length byte.
// Result channel out_ch: one result per good frame with a nonzero key,
// carrying every held value; the result appears in the cycle after the
// request that carries the last frame byte.
// Throughput: one request per cycle. The only limit is the result register:
// while it holds an untaken result, the request that arrives at byte 15 of a
// synced frame, byte or resync alike, is held off; all other requests flow
// freely.
// Reset: receiver waits for the length byte, all held values read zero,
// no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module vtx_response_frame_receiver (
	input wire logic  clk,
	input wire logic  arst_n,
	vrx_in_if.sink    in_ch,
	vrx_out_if.source out_ch
);
	import vrx_pkg::*;

	frame_evt_t evt;
	logic       last_byte;
	logic       room;
	logic       fire;

	assign in_ch.ready = !last_byte || room;
	assign fire        = in_ch.valid && in_ch.ready;

	vrx_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.req       (in_ch.item),
		.evt       (evt),
		.last_byte (last_byte)
	);

	vrx_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_item  (out_ch.item),
		.room      (room)
	);

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the video-transmitter response frame receiver.
//
// Bytes go in through the request channel under random gaps, results come out
// under random back-pressure. A behavioral decoder follows every accepted
// request and queues the result it predicts. Each result from the block is
// compared field by field with the oldest queued one. A short table of frames
// covers field extremes and every drop case. Random frames follow, mostly
// well formed, mixed with noise bytes, resyncs, cut and corrupted frames.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import vrx_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 12;
	localparam int NUM_ITEMS    = 1100;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 20;

	// How a table row fixes the outcome of its last byte
	typedef enum logic [1:0] {
		PIN_NONE   = 2'd0,
		PIN_RESULT = 2'd1,
		PIN_SILENT = 2'd2
	} pin_mode_t;

	// One frame to send, with optional corruption
	typedef struct packed {
		logic [1:0]  njunk;
		logic [7:0]  junk;
		logic [7:0]  code;
		logic [15:0] w2;
		logic [15:0] w4;
		logic [15:0] w6;
		logic [15:0] w8;
		logic [31:0] pad;
		logic [7:0]  sum_err;
		logic [7:0]  tail;
		logic [3:0]  cut;
		pin_mode_t   pin_mode;
		out_item_t   pin;
	} frame_row_t;

	// One request as the driver holds it
	typedef struct packed {
		in_item_t  req;
		pin_mode_t pin_mode;
		out_item_t pin;
	} tb_req_t;

	localparam logic [7:0] RESP_CODES [3] = '{CODE_LIMITS, CODE_SETTINGS, CODE_TEMP};
	localparam out_item_t NO_PIN = '0;

	// Directed frames; a pinned result follows from the held values at a glance
	localparam frame_row_t DIRECTED_ROWS [15] = '{
		'{2'd2, 8'h00, CODE_LIMITS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_RESULT, '{KIND_LIMITS, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'h0, 16'h0, 8'h0, 16'h0, 16'h0}},
		'{2'd0, 8'h00, CODE_SETTINGS, 16'hFFFF, 16'hFFFF, 16'hFF00, 16'hFFFF, 32'hFFFFFFFF,
			8'h0, 8'h0, 4'd0, PIN_RESULT, '{KIND_SETTINGS, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'h0}},
		'{2'd0, 8'h00, CODE_TEMP, 16'h0, 16'h0, 16'h8000, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_RESULT, '{KIND_TEMP, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'h8000}},
		'{2'd3, 8'hFF, CODE_TEMP, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 32'hFFFFFFFF,
			8'h0, 8'h0, 4'd0, PIN_RESULT, '{KIND_TEMP, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'h7FFF}},
		// zero key, bad checksum, nonzero last byte, zero temperature key
		'{2'd0, 8'h00, CODE_LIMITS, 16'h0, 16'h1234, 16'h5678, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_SILENT, NO_PIN},
		'{2'd0, 8'h00, CODE_SETTINGS, 16'h1, 16'h0, 16'h0, 16'h0, 32'h0, 8'h01, 8'h0,
			4'd0, PIN_SILENT, NO_PIN},
		'{2'd0, 8'h00, CODE_LIMITS, 16'h1, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 8'h80,
			4'd0, PIN_SILENT, NO_PIN},
		'{2'd0, 8'h00, CODE_TEMP, 16'hFFFF, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_SILENT, NO_PIN},
		// resync mid-frame, unknown code, length byte twice, resync before last byte
		'{2'd0, 8'h00, CODE_LIMITS, 16'h1, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd7, PIN_NONE, NO_PIN},
		'{2'd0, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_NONE, NO_PIN},
		'{2'd1, LEN_BYTE, CODE_LIMITS, 16'h1, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_NONE, NO_PIN},
		'{2'd0, 8'h00, CODE_LIMITS, 16'h2, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd15, PIN_NONE, NO_PIN},
		// low extremes; untouched held values carry over
		'{2'd0, 8'h00, CODE_LIMITS, 16'h1, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_RESULT, '{KIND_LIMITS, 16'h1, 16'h0, 16'h0,
			16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'h7FFF}},
		'{2'd0, 8'h00, CODE_SETTINGS, 16'h1, 16'h0, 16'h0, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_RESULT, '{KIND_SETTINGS, 16'h1, 16'h0, 16'h0,
			16'h1, 16'h0, 8'h0, 16'h0, 16'h7FFF}},
		'{2'd0, 8'h00, CODE_TEMP, 16'h0, 16'h0, 16'hFFFF, 16'h0, 32'h0, 8'h0, 8'h0,
			4'd0, PIN_RESULT, '{KIND_TEMP, 16'h1, 16'h0, 16'h0,
			16'h1, 16'h0, 8'h0, 16'h0, 16'hFFFF}}
	};

	logic clk = 1'b0;
	logic arst_n;

	vrx_in_if  in_ch ();
	vrx_out_if out_ch ();

	vtx_response_frame_receiver DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Decoder state
	rx_phase_t  rx_ph;
	logic [4:0] rx_pos;
	logic [7:0] rx_buf [16];
	logic [7:0] rx_sum;
	out_item_t  held;

	out_item_t decoded_q [$];
	tb_req_t   pending;
	int        mismatches = 0;
	int        sent = 0;
	int        cycles = 0;
	logic      quiet = 1'b0;

	function automatic void resync_decoder();
		rx_ph  = PH_WAIT_LEN;
		rx_pos = '0;
		rx_sum = '0;
	endfunction

	// Advance the decoder by one request; has is set when a result is due
	function automatic void decode_byte(input in_item_t req, output bit has,
			output out_item_t res);
		logic [3:0]  p;
		logic [7:0]  b;
		logic [15:0] key;
		logic        good;
		has = 1'b0;
		res = '0;
		b   = req.rx_byte;
		if (req.action == ACT_RESYNC) begin
			resync_decoder();
			return;
		end
		p = rx_pos[3:0];
		rx_buf[p] = b;
		if (p >= 1 && p < CksumPos) begin
			rx_sum = rx_sum + b;
		end
		rx_pos = 5'(p) + 5'd1;
		case (rx_ph)
			PH_WAIT_LEN: begin
				if (b == LEN_BYTE) begin
					rx_ph = PH_WAIT_CODE;
				end else begin
					rx_pos = '0;
					rx_sum = '0;
				end
			end
			PH_WAIT_CODE: begin
				if (b == CODE_LIMITS || b == CODE_SETTINGS || b == CODE_TEMP) begin
					rx_ph = PH_DATA;
				end else begin
					resync_decoder();
				end
			end
			PH_DATA: begin
				if (rx_pos == 5'(FrameLen)) begin
					good = (rx_buf[CksumPos] == rx_sum) && (rx_buf[15] == 8'h00);
					resync_decoder();
					if (good) begin
						case (rx_buf[1])
							CODE_LIMITS: begin
								key = {rx_buf[3], rx_buf[2]};
								if (key != 0) begin
									held.min_frequency = key;
									held.max_frequency = {rx_buf[5], rx_buf[4]};
									held.max_power     = {rx_buf[7], rx_buf[6]};
									held.response_kind = KIND_LIMITS;
									has = 1'b1;
								end
							end
							CODE_SETTINGS: begin
								key = {rx_buf[3], rx_buf[2]};
								if (key != 0) begin
									held.current_frequency = key;
									held.configured_power  = {rx_buf[5], rx_buf[4]};
									held.pit_mode          = rx_buf[7];
									held.actual_power      = {rx_buf[9], rx_buf[8]};
									held.response_kind     = KIND_SETTINGS;
									has = 1'b1;
								end
							end
							CODE_TEMP: begin
								key = {rx_buf[7], rx_buf[6]};
								if (key != 0) begin
									held.temperature   = key;
									held.response_kind = KIND_TEMP;
									has = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			default: resync_decoder();
		endcase
		res = held;
	endfunction

	// Mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return 8'h00;
		if (r < 30) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic tb_req_t make_req(input logic act, input logic [7:0] b);
		tb_req_t r;
		r = '0;
		r.req.action  = act;
		r.req.rx_byte = b;
		r.pin_mode    = PIN_NONE;
		return r;
	endfunction

	// Mostly well-formed frames with random content, some broken
	function automatic frame_row_t rand_frame();
		frame_row_t f;
		f = '0;
		if ($urandom_range(0, 19) == 0) begin
			f.code = 8'($urandom_range(0, 255));
		end else begin
			f.code = RESP_CODES[$urandom_range(0, 2)];
		end
		f.w2  = {rand_byte(), rand_byte()};
		f.w4  = {rand_byte(), rand_byte()};
		f.w6  = {rand_byte(), rand_byte()};
		f.w8  = {rand_byte(), rand_byte()};
		f.pad = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
		if ($urandom_range(0, 19) == 0) begin
			if (f.code == CODE_TEMP) f.w6 = '0;
			else f.w2 = '0;
		end
		if ($urandom_range(0, 19) == 0) f.sum_err = 8'($urandom_range(1, 255));
		if ($urandom_range(0, 19) == 0) f.tail = 8'($urandom_range(1, 255));
		if ($urandom_range(0, 19) == 0) f.cut = 4'($urandom_range(1, 15));
		f.pin_mode = PIN_NONE;
		return f;
	endfunction

	// Drive one request from a falling edge and hold it until accepted
	task automatic send_req(input tb_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pending     = r;
		in_ch.item  = r.req;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// Build the bytes of a frame, checksum included, and send them
	task automatic send_frame(input frame_row_t f);
		logic [7:0] fb [16];
		logic [7:0] sum;
		tb_req_t    r;
		int         n;
		fb[0]  = LEN_BYTE;
		fb[1]  = f.code;
		fb[2]  = f.w2[7:0];
		fb[3]  = f.w2[15:8];
		fb[4]  = f.w4[7:0];
		fb[5]  = f.w4[15:8];
		fb[6]  = f.w6[7:0];
		fb[7]  = f.w6[15:8];
		fb[8]  = f.w8[7:0];
		fb[9]  = f.w8[15:8];
		fb[10] = f.pad[7:0];
		fb[11] = f.pad[15:8];
		fb[12] = f.pad[23:16];
		fb[13] = f.pad[31:24];
		sum = '0;
		for (int i = 1; i < CksumPos; i++) begin
			sum = sum + fb[i];
		end
		fb[14] = sum ^ f.sum_err;
		fb[15] = f.tail;
		n = (f.cut != 0) ? int'(f.cut) : FrameLen;
		for (int i = 0; i < f.njunk; i++) begin
			send_req(make_req(ACT_BYTE, f.junk));
		end
		for (int i = 0; i < n; i++) begin
			r = make_req(ACT_BYTE, fb[i]);
			if (i == FrameLen - 1) begin
				r.pin_mode = f.pin_mode;
				r.pin      = f.pin;
			end
			send_req(r);
		end
		if (f.cut != 0) begin
			send_req(make_req(ACT_RESYNC, 8'($urandom_range(0, 255))));
		end
	endtask

	task automatic wait_drained();
		while (decoded_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_field(input string fname, input logic [15:0] e,
			input logic [15:0] a);
		if (e !== a) begin
			$display("%0t ns: %s expected %h actual %h", $time, fname, e, a);
			mismatches++;
		end
	endtask

	task automatic check_result(input out_item_t e, input out_item_t a);
		check_field("response_kind", 16'(e.response_kind), 16'(a.response_kind));
		check_field("min_frequency", e.min_frequency, a.min_frequency);
		check_field("max_frequency", e.max_frequency, a.max_frequency);
		check_field("max_power", e.max_power, a.max_power);
		check_field("current_frequency", e.current_frequency, a.current_frequency);
		check_field("configured_power", e.configured_power, a.configured_power);
		check_field("pit_mode", 16'(e.pit_mode), 16'(a.pit_mode));
		check_field("actual_power", e.actual_power, a.actual_power);
		check_field("temperature", e.temperature, a.temperature);
	endtask

	// Check results first, then predict from the request taken at this edge
	always @(posedge clk) begin
		bit        has;
		out_item_t res;
		if (arst_n) begin
			if (out_ch.valid === 1'b1 && out_ch.ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t ns: unexpected result, kind %0d", $time,
						out_ch.item.response_kind);
					mismatches++;
				end else begin
					check_result(decoded_q.pop_front(), out_ch.item);
				end
			end
			if (in_ch.valid && in_ch.ready === 1'b1) begin
				decode_byte(pending.req, has, res);
				case (pending.pin_mode)
					PIN_RESULT: begin
						if (!has || res != pending.pin) begin
							$display("%0t ns: table expects %h, prediction %h (due %0d)",
								$time, pending.pin, res, has);
							mismatches++;
						end
						decoded_q.push_back(pending.pin);
					end
					PIN_SILENT: begin
						if (has) begin
							$display("%0t ns: table expects no result, prediction %h",
								$time, res);
							mismatches++;
						end
					end
					default: begin
						if (has) decoded_q.push_back(res);
					end
				endcase
			end
		end
	end

	// Stall the result channel at random
	initial begin
		int hold;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				out_ch.ready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// End the run on a hang
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		int nframes;
		in_ch.valid = 1'b0;
		in_ch.item  = '0;
		arst_n      = 1'b0;
		held        = '0;
		resync_decoder();
		foreach (rx_buf[i]) rx_buf[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		foreach (DIRECTED_ROWS[i]) begin
			send_frame(DIRECTED_ROWS[i]);
		end

		// Random frames with noise, resyncs and drained pauses
		wait_drained();
		nframes = 0;
		while (sent < NUM_ITEMS) begin
			if (nframes % 10 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			if (nframes % 25 == 24) begin
				wait_drained();
			end
			if ($urandom_range(0, 99) < 8) begin
				repeat ($urandom_range(1, 4)) begin
					send_req(make_req(ACT_BYTE, 8'($urandom_range(0, 255))));
				end
			end
			if ($urandom_range(0, 99) < 3) begin
				send_req(make_req(ACT_RESYNC, 8'($urandom_range(0, 255))));
			end
			send_frame(rand_frame());
			nframes++;
		end
		in_ch.valid = 1'b0;
		quiet       = 1'b0;

		// Drain, then allow for the result latency
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
